>>> hw/rtl/crcs_pkg.sv
// crcs_pkg: shared constants, types and operation codes of the curve sampler
// used by the interfaces, the step generator, the shared multiply unit and the top level
// no dependencies

package crcs_pkg;

    // number formats
    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_SAMPLES = 32;
    localparam int NUM_COORDS  = 3;

    // configuration register
    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd8;

    // sample counter widths
    localparam int N_W = $clog2(MAX_SAMPLES + 1);
    localparam int J_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // curve parameter t, one integer bit above the fraction
    localparam int T_W = FRAC_BITS + 1;

    // horner accumulator, multiplied in two halves
    localparam int ACC_W    = 40;
    localparam int SPLIT_W  = ACC_W / 2;
    localparam int MUL_A_W  = ACC_W - SPLIT_W + 1;
    localparam int MUL_P_W  = MUL_A_W + T_W + 1;
    localparam int PROD_W   = MUL_P_W + SPLIT_W;
    localparam logic [MUL_P_W-1:0] ROUND_HALF = MUL_P_W'(1) << (FRAC_BITS - 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0] coord_idx_t;
    localparam coord_idx_t LAST_COORD = coord_idx_t'(NUM_COORDS - 1);

    // shared unit operations
    typedef logic [2:0] mac_op_t;
    localparam mac_op_t OP_NONE = 3'd0;
    localparam mac_op_t OP_LOAD = 3'd1;
    localparam mac_op_t OP_LO   = 3'd2;
    localparam mac_op_t OP_HI   = 3'd3;
    localparam mac_op_t OP_ACC  = 3'd4;

    // horner steps, named by the coefficient added
    typedef logic [1:0] step_t;
    localparam step_t STEP_B  = 2'd1;
    localparam step_t STEP_A  = 2'd2;
    localparam step_t STEP_P1 = 2'd3;

    typedef struct packed {
        mac_op_t op;
        step_t   step;
    } mac_ctrl_t;

    typedef struct packed {
        logic restart;
        logic advance;
    } tgen_ctrl_t;

endpackage

>>> hw/rtl/crcs_if.sv
// crcs_if: valid/ready channel interfaces for control points and curve samples
// depends on crcs_pkg

interface crcs_point_if;
    import crcs_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   final_point;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output final_point, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input final_point, output ready);
endinterface

interface crcs_sample_if;
    import crcs_pkg::*;

    logic   valid;
    logic   ready;
    coord_t sample_x;
    coord_t sample_y;
    coord_t sample_z;
    logic   run_end;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    output run_end, input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    input run_end, output ready);
endinterface

>>> hw/rtl/crcs_tgen.sv
// crcs_tgen: steps t = floor(j * 2^FRAC_BITS / n) for j = 0..n-1 without a divider
// keeps quotient and remainder of the step from an elaboration-time table; depends on crcs_pkg

module crcs_tgen (
    input  logic                      clk,
    input  logic                      rst_n,
    input  crcs_pkg::tgen_ctrl_t      ctrl,
    input  logic [crcs_pkg::N_W-1:0]  n,
    output logic [crcs_pkg::T_W-1:0]  t,
    output logic                      last
);
    import crcs_pkg::*;

    logic [T_W-1:0] q_tab [MAX_SAMPLES];
    logic [N_W-1:0] r_tab [MAX_SAMPLES];

    logic [J_W-1:0] j_reg, j_next;
    logic [T_W-1:0] t_reg, t_next;
    logic [N_W-1:0] rem_reg, rem_next;

    logic [J_W-1:0] tab_idx;
    logic [N_W:0]   rem_sum;
    logic           carry;

    // step quotient and remainder of 2^FRAC_BITS / n for every n
    for (genvar g = 1; g <= MAX_SAMPLES; g++)
    begin : g_step_tab
        localparam int unsigned QV = (1 << FRAC_BITS) / g;
        localparam int unsigned RV = (1 << FRAC_BITS) % g;
        assign q_tab[g-1] = T_W'(QV);
        assign r_tab[g-1] = N_W'(RV);
    end

    assign tab_idx = J_W'(n - N_W'(1));
    assign rem_sum = {1'b0, rem_reg} + {1'b0, r_tab[tab_idx]};
    assign carry   = (rem_sum >= {1'b0, n});

    // next sample position
    always_comb
    begin
        j_next   = j_reg;
        t_next   = t_reg;
        rem_next = rem_reg;
        if (ctrl.restart)
        begin
            j_next   = '0;
            t_next   = '0;
            rem_next = '0;
        end
        else if (ctrl.advance)
        begin
            j_next = j_reg + J_W'(1);
            if (carry)
            begin
                rem_next = N_W'(rem_sum - {1'b0, n});
                t_next   = t_reg + q_tab[tab_idx] + T_W'(1);
            end
            else
            begin
                rem_next = N_W'(rem_sum);
                t_next   = t_reg + q_tab[tab_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg   <= '0;
            t_reg   <= '0;
            rem_reg <= '0;
        end
        else
        begin
            j_reg   <= j_next;
            t_reg   <= t_next;
            rem_reg <= rem_next;
        end
    end

    assign t    = t_reg;
    assign last = (N_W'(j_reg) == (n - N_W'(1)));

endmodule

>>> hw/rtl/crcs_mac.sv
// crcs_mac: shared horner unit, one split multiplier with rounding accumulate and saturation
// evaluates one coordinate of the cubic per sequence of operations; depends on crcs_pkg

module crcs_mac (
    input  logic                      clk,
    input  crcs_pkg::mac_ctrl_t       ctrl,
    input  crcs_pkg::coord_t          p0,
    input  crcs_pkg::coord_t          p1,
    input  crcs_pkg::coord_t          p2,
    input  crcs_pkg::coord_t          p3,
    input  logic [crcs_pkg::T_W-1:0]  t,
    output crcs_pkg::coord_t          sat_val
);
    import crcs_pkg::*;

    logic signed [ACC_W-1:0]   r_reg;
    logic signed [ACC_W-1:0]   addend_reg;
    logic [MUL_P_W-1:0]        lo_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [ACC_W-1:0]   e0, e1, e2, e3, d12;
    logic signed [ACC_W-1:0]   coef_a, coef_b, coef_c, two_p1, addend_sel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [PROD_W-1:0]  hi_ext, prod_sum, prod_shr;
    logic signed [ACC_W:0]     r_inc;
    logic signed [ACC_W-1:0]   r_half;
    logic                      ovf;

    // polynomial coefficients of the current coordinate
    assign e0     = ACC_W'(p0);
    assign e1     = ACC_W'(p1);
    assign e2     = ACC_W'(p2);
    assign e3     = ACC_W'(p3);
    assign d12    = e1 - e2;
    assign coef_a = e2 - e0;
    assign coef_b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    assign coef_c = (d12 <<< 1) + d12 + e3 - e0;
    assign two_p1 = e1 <<< 1;

    always_comb
    begin
        case (ctrl.step)
            STEP_B:  addend_sel = coef_b;
            STEP_A:  addend_sel = coef_a;
            default: addend_sel = two_p1;
        endcase
    end

    // the shared multiplier: low half first, then signed high half
    assign mul_a = (ctrl.op == OP_LO) ? $signed({1'b0, r_reg[SPLIT_W-1:0]})
                                      : $signed({r_reg[ACC_W-1], r_reg[ACC_W-1:SPLIT_W]});
    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'($signed({1'b0, t}));

    // recombine halves, then round and drop the fraction
    assign hi_ext   = {{(PROD_W-MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
    assign prod_sum = (hi_ext <<< SPLIT_W) + $signed({{(PROD_W-MUL_P_W){1'b0}}, lo_reg});
    assign prod_shr = prod_reg >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD: r_reg <= coef_c;
            OP_LO:
            begin
                lo_reg     <= MUL_P_W'(mul_p) + ROUND_HALF;
                addend_reg <= addend_sel;
            end
            OP_HI:   prod_reg <= prod_sum;
            OP_ACC:  r_reg <= prod_shr[ACC_W-1:0] + addend_reg;
            default:
            begin
            end
        endcase
    end

    // halve with rounding toward plus infinity, then clamp to the coordinate range
    assign r_inc  = {r_reg[ACC_W-1], r_reg} + (ACC_W+1)'(1);
    assign r_half = r_inc[ACC_W:1];
    assign ovf    = (r_half[ACC_W-1:COORD_W-1] != {(ACC_W-COORD_W+1){1'b0}}) &&
                    (r_half[ACC_W-1:COORD_W-1] != {(ACC_W-COORD_W+1){1'b1}});

    always_comb
    begin
        if (!ovf)
            sat_val = r_half[COORD_W-1:0];
        else if (r_half[ACC_W-1])
            sat_val = {1'b1, {(COORD_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(COORD_W-1){1'b1}}};
    end

endmodule

>>> hw/rtl/catmull_rom_curve_sampler.sv
// catmull_rom_curve_sampler: streaming uniform catmull-rom sampler over 3d control points
// depends on crcs_pkg, crcs_if, crcs_tgen, crcs_mac
//
// points: one control point per transaction (signed Q16.16 x, y, z and final_point).
// samples: curve samples; run_end marks the last sample caused by one point.
// cfg_we / cfg_wdata: samples per segment n (0 acts as 1, above 32 acts as 32).
// the third and later points of a trail each give one segment of n samples; the final
// point also flushes the closing segment; the second point gives a segment only when final.
// all arithmetic runs through one multiplier under a sequencer: per coordinate a load,
// three horner steps (each a low half, a high half and an accumulate) and a saturation
// step, then an emit state per sample; the block is ready for a point again once it has
// emitted the last of its samples (up to 64).
// an output register holds the current sample; the next one is computed meanwhile and the
// sequencer waits only when that register is still full; points are taken while the last
// sample of the previous point still waits.
// reset clears the point history and the sample counter and sets n to 8.

module catmull_rom_curve_sampler (
    input  logic                        clk,
    input  logic                        rst_n,
    crcs_point_if.sink                  points,
    crcs_sample_if.source               samples,
    input  logic                        cfg_we,
    input  logic [crcs_pkg::CFG_W-1:0]  cfg_wdata
);
    import crcs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_LO   = 3'd2;
    localparam logic [2:0] ST_HI   = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_SAT  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]       state_reg, state_next;
    coord_idx_t       coord_reg, coord_next;
    step_t            step_reg, step_next;
    logic [1:0]       seen_reg, seen_next;
    logic             fin_reg, fin_next;
    logic             seg_fin_reg, seg_fin_next;
    logic [CFG_W-1:0] cfg_n_reg;

    coord_t h0_reg [NUM_COORDS];
    coord_t h1_reg [NUM_COORDS];
    coord_t h2_reg [NUM_COORDS];
    coord_t nw_reg [NUM_COORDS];
    coord_t smp_reg [NUM_COORDS];

    coord_t out_x_reg, out_y_reg, out_z_reg;
    logic   out_run_end_reg;
    logic   out_valid_reg, out_valid_next;

    coord_t     in_pt [NUM_COORDS];
    coord_t     upd_pt [NUM_COORDS];
    logic       upd_fin;
    logic       hist_upd;
    logic       in_acc;
    logic       no_seg;
    logic       emit_go;
    logic       sample_last;
    logic       tgen_last;
    logic [T_W-1:0] t_val;
    logic [N_W-1:0] n_eff;
    coord_t     sel_p0, sel_p1, sel_p2, sel_p3, sat_val;
    mac_ctrl_t  mac_ctrl;
    tgen_ctrl_t tgen_ctrl;

    // configuration register and effective sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_n_reg <= CFG_RESET;
        else if (cfg_we)
            cfg_n_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (cfg_n_reg == '0)
            n_eff = N_W'(1);
        else if (cfg_n_reg > CFG_W'(MAX_SAMPLES))
            n_eff = N_W'(MAX_SAMPLES);
        else
            n_eff = N_W'(cfg_n_reg);
    end

    // input transaction
    assign in_pt[0]     = points.point_x;
    assign in_pt[1]     = points.point_y;
    assign in_pt[2]     = points.point_z;
    assign points.ready = (state_reg == ST_IDLE);
    assign in_acc       = points.valid && points.ready;
    assign no_seg       = (seen_reg == 2'd0) || ((seen_reg == 2'd1) && !points.final_point);

    // segment end points for the current coordinate
    always_comb
    begin
        if (seg_fin_reg)
        begin
            sel_p0 = (seen_reg == 2'd1) ? h2_reg[coord_reg] : h1_reg[coord_reg];
            sel_p1 = h2_reg[coord_reg];
            sel_p2 = nw_reg[coord_reg];
        end
        else
        begin
            sel_p0 = (seen_reg == 2'd3) ? h0_reg[coord_reg] : h1_reg[coord_reg];
            sel_p1 = h1_reg[coord_reg];
            sel_p2 = h2_reg[coord_reg];
        end
        sel_p3 = nw_reg[coord_reg];
    end

    assign emit_go     = !out_valid_reg || samples.ready;
    assign sample_last = tgen_last && (seg_fin_reg || !fin_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        coord_next     = coord_reg;
        step_next      = step_reg;
        fin_next       = fin_reg;
        seg_fin_next   = seg_fin_reg;
        hist_upd       = 1'b0;
        upd_fin        = fin_reg;
        upd_pt         = nw_reg;
        tgen_ctrl      = '0;
        mac_ctrl.op    = OP_NONE;
        mac_ctrl.step  = step_reg;
        out_valid_next = out_valid_reg && !samples.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    fin_next = points.final_point;
                    if (no_seg)
                    begin
                        hist_upd = 1'b1;
                        upd_fin  = points.final_point;
                        upd_pt   = in_pt;
                    end
                    else
                    begin
                        seg_fin_next      = (seen_reg == 2'd1);
                        tgen_ctrl.restart = 1'b1;
                        coord_next        = '0;
                        state_next        = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                mac_ctrl.op = OP_LOAD;
                step_next   = STEP_B;
                state_next  = ST_LO;
            end
            ST_LO:
            begin
                mac_ctrl.op = OP_LO;
                state_next  = ST_HI;
            end
            ST_HI:
            begin
                mac_ctrl.op = OP_HI;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                mac_ctrl.op = OP_ACC;
                if (step_reg == STEP_P1)
                    state_next = ST_SAT;
                else
                begin
                    step_next  = step_reg + step_t'(1);
                    state_next = ST_LO;
                end
            end
            ST_SAT:
            begin
                if (coord_reg == LAST_COORD)
                    state_next = ST_EMIT;
                else
                begin
                    coord_next = coord_reg + coord_idx_t'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    coord_next     = '0;
                    if (!tgen_last)
                    begin
                        tgen_ctrl.advance = 1'b1;
                        state_next        = ST_LOAD;
                    end
                    else if (!sample_last)
                    begin
                        seg_fin_next      = 1'b1;
                        tgen_ctrl.restart = 1'b1;
                        state_next        = ST_LOAD;
                    end
                    else
                    begin
                        hist_upd   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign seen_next = !hist_upd ? seen_reg :
                       upd_fin ? 2'd0 :
                       (seen_reg == 2'd3) ? seen_reg : seen_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            coord_reg     <= '0;
            step_reg      <= STEP_B;
            seen_reg      <= '0;
            fin_reg       <= 1'b0;
            seg_fin_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            coord_reg     <= coord_next;
            step_reg      <= step_next;
            seen_reg      <= seen_next;
            fin_reg       <= fin_next;
            seg_fin_reg   <= seg_fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // point history, cleared at reset and after a final point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                h0_reg[k] <= '0;
                h1_reg[k] <= '0;
                h2_reg[k] <= '0;
            end
        end
        else if (hist_upd)
        begin
            for (int k = 0; k < NUM_COORDS; k++)
            begin
                h0_reg[k] <= upd_fin ? '0 : h1_reg[k];
                h1_reg[k] <= upd_fin ? '0 : h2_reg[k];
                h2_reg[k] <= upd_fin ? '0 : upd_pt[k];
            end
        end
    end

    // newest point and finished coordinates
    always_ff @(posedge clk)
    begin
        if (in_acc)
            nw_reg <= in_pt;
        if (state_reg == ST_SAT)
            smp_reg[coord_reg] <= sat_val;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && emit_go)
        begin
            out_x_reg       <= smp_reg[0];
            out_y_reg       <= smp_reg[1];
            out_z_reg       <= smp_reg[2];
            out_run_end_reg <= sample_last;
        end
    end

    assign samples.valid    = out_valid_reg;
    assign samples.sample_x = out_x_reg;
    assign samples.sample_y = out_y_reg;
    assign samples.sample_z = out_z_reg;
    assign samples.run_end  = out_run_end_reg;

    // curve parameter stepping
    crcs_tgen u_tgen (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tgen_ctrl),
        .n     (n_eff),
        .t     (t_val),
        .last  (tgen_last)
    );

    // shared horner unit
    crcs_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .p0      (sel_p0),
        .p1      (sel_p1),
        .p2      (sel_p2),
        .p3      (sel_p3),
        .t       (t_val),
        .sat_val (sat_val)
    );

`ifndef SYNTHESIS
    // t stays below one while a sample is multiplied
    a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LO) |-> (t_val[T_W-1] == 1'b0))
        else $error("curve parameter reached one during a multiply");

    // an empty trail has an all-zero history
    a_empty_history: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && seen_reg == 2'd0) |->
        (h2_reg[0] == '0 && h2_reg[1] == '0 && h2_reg[2] == '0 &&
         h1_reg[0] == '0 && h1_reg[1] == '0 && h1_reg[2] == '0))
        else $error("history not cleared for a new trail");

    // horner step index valid while the multiplier is in use
    a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LO || state_reg == ST_HI || state_reg == ST_ACC) |->
        (step_reg == STEP_B || step_reg == STEP_A || step_reg == STEP_P1))
        else $error("horner step out of sequence");

    // the sample flagged run_end closes the point's work
    a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_go && sample_last) |=>
        (state_reg == ST_IDLE && samples.valid && samples.run_end))
        else $error("work continued past the last sample of a point");
`endif

endmodule
